>>> hdl/sc3x_pkg.sv
// Shared constants for the Scale3x column upscaler.
// No dependencies; used by sc3x_kernel and scale3x_pixel_upscaler.
`timescale 1ns / 1ps

package sc3x_pkg;

  localparam int PORT_BITS = 32;

  localparam int COL_DEPTH = 3;
  localparam int ROW_ABOVE  = 0;
  localparam int ROW_CENTRE = 1;
  localparam int ROW_BELOW  = 2;

  localparam int BLOCK_PIX = 9;

endpackage

>>> hdl/sc3x_kernel.sv
// Combinational Scale3x rules: turns a 3x3 source neighborhood into a 3x3 block.
// Depends on sc3x_pkg for the row indexes inside a column.
`timescale 1ns / 1ps

module sc3x_kernel #(
  parameter int PIXEL_BITS = 32
) (
  input  logic [sc3x_pkg::COL_DEPTH-1:0][PIXEL_BITS-1:0] lc,
  input  logic [sc3x_pkg::COL_DEPTH-1:0][PIXEL_BITS-1:0] cc,
  input  logic [sc3x_pkg::COL_DEPTH-1:0][PIXEL_BITS-1:0] rc,
  output logic [sc3x_pkg::BLOCK_PIX-1:0][PIXEL_BITS-1:0] blk
);

  typedef logic [2:0][PIXEL_BITS-1:0] row_t;

  // The top and bottom rows share one rule; near is the line on the row's side.
  function automatic row_t half_row(input logic [PIXEL_BITS-1:0] e,
                                    input logic [PIXEL_BITS-1:0] d,
                                    input logic [PIXEL_BITS-1:0] f,
                                    input logic [PIXEL_BITS-1:0] near,
                                    input logic [PIXEL_BITS-1:0] far,
                                    input logic [PIXEL_BITS-1:0] near_r,
                                    input logic [PIXEL_BITS-1:0] near_l);
    row_t o;
    logic go;
    go   = (d != f) && (near != far);
    o[0] = (go && near == d) ? near : e;
    o[1] = (go && ((near == d && e != near_r) || (near == f && e != near_l))) ? near : e;
    o[2] = (go && near == f) ? near : e;
    return o;
  endfunction

  logic [PIXEL_BITS-1:0] e, d, f, b, h;
  logic                  mid_go;
  row_t                  top_row, bot_row;

  assign e = cc[sc3x_pkg::ROW_CENTRE];
  assign d = lc[sc3x_pkg::ROW_CENTRE];
  assign f = rc[sc3x_pkg::ROW_CENTRE];
  assign b = cc[sc3x_pkg::ROW_ABOVE];
  assign h = cc[sc3x_pkg::ROW_BELOW];

  assign top_row = half_row(e, d, f, b, h, rc[sc3x_pkg::ROW_ABOVE], lc[sc3x_pkg::ROW_ABOVE]);
  assign bot_row = half_row(e, d, f, h, b, rc[sc3x_pkg::ROW_BELOW], lc[sc3x_pkg::ROW_BELOW]);
  assign mid_go  = (d != f) && (b != h);

  always_comb begin
    blk[0] = top_row[0];
    blk[1] = top_row[1];
    blk[2] = top_row[2];
    blk[3] = (mid_go && ((d == b && e != lc[sc3x_pkg::ROW_BELOW]) ||
                         (d == h && e != lc[sc3x_pkg::ROW_ABOVE]))) ? d : e;
    blk[4] = e;
    blk[5] = (mid_go && ((f == b && e != rc[sc3x_pkg::ROW_BELOW]) ||
                         (f == h && e != rc[sc3x_pkg::ROW_ABOVE]))) ? f : e;
    blk[6] = bot_row[0];
    blk[7] = bot_row[1];
    blk[8] = bot_row[2];
  end

endmodule

>>> hdl/scale3x_pixel_upscaler.sv
// Accepted columns pass through the job stage, then the registered output stage.
// Throughput: one column word per cycle unless the output stalls; a column that
// ends a line after the first yields two blocks and holds the input until the second moves.
// Reset (rst_n, synchronous, active low) empties the job and output stages and
// restarts the line; the column holding registers need no clearing.
// Depends on sc3x_pkg and sc3x_kernel.
`timescale 1ns / 1ps

module scale3x_pixel_upscaler #(
  parameter int PIXEL_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sc3x_pkg::PORT_BITS-1:0] in_pix_above,
  input  logic [sc3x_pkg::PORT_BITS-1:0] in_pix_center,
  input  logic [sc3x_pkg::PORT_BITS-1:0] in_pix_below,
  input  logic                          in_line_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sc3x_pkg::PORT_BITS-1:0] out_r0c0,
  output logic [sc3x_pkg::PORT_BITS-1:0] out_r0c1,
  output logic [sc3x_pkg::PORT_BITS-1:0] out_r0c2,
  output logic [sc3x_pkg::PORT_BITS-1:0] out_r1c0,
  output logic [sc3x_pkg::PORT_BITS-1:0] out_r1c1,
  output logic [sc3x_pkg::PORT_BITS-1:0] out_r1c2,
  output logic [sc3x_pkg::PORT_BITS-1:0] out_r2c0,
  output logic [sc3x_pkg::PORT_BITS-1:0] out_r2c1,
  output logic [sc3x_pkg::PORT_BITS-1:0] out_r2c2,
  output logic                          out_block_line_last,
  output logic                          out_run_last
);

  typedef logic [sc3x_pkg::COL_DEPTH-1:0][PIXEL_BITS-1:0] column_t;
  typedef logic [sc3x_pkg::BLOCK_PIX-1:0][PIXEL_BITS-1:0] block_t;

  column_t col_in;
  column_t lcol_r, ccol_r;
  column_t job_lc_r, job_cc_r, job_rc_r;
  column_t k_lc, k_cc;
  block_t  blk, out_pix_r;

  logic line_started_r;
  logic job_valid_r, job_phase_r, job_two_r, job_edge_r;
  logic out_valid_r, out_line_last_r, out_run_last_r;
  logic move, job_done, in_fire, makes_job;

  assign col_in[sc3x_pkg::ROW_ABOVE]  = in_pix_above[PIXEL_BITS-1:0];
  assign col_in[sc3x_pkg::ROW_CENTRE] = in_pix_center[PIXEL_BITS-1:0];
  assign col_in[sc3x_pkg::ROW_BELOW]  = in_pix_below[PIXEL_BITS-1:0];

  assign move      = job_valid_r && (!out_valid_r || out_ready);
  assign job_done  = move && (!job_two_r || job_phase_r);
  assign in_ready  = !job_valid_r || job_done;
  assign in_fire   = in_valid && in_ready;
  assign makes_job = in_fire && (line_started_r || in_line_end);

  // The second block of a line end treats the newest column as centre and right.
  assign k_lc = job_phase_r ? job_cc_r : job_lc_r;
  assign k_cc = job_phase_r ? job_rc_r : job_cc_r;

  sc3x_kernel #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_kernel (
    .lc  (k_lc),
    .cc  (k_cc),
    .rc  (job_rc_r),
    .blk (blk)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_started_r <= 1'b0;
      job_valid_r    <= 1'b0;
      job_phase_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        line_started_r <= !in_line_end;
      end
      if (makes_job) begin
        job_valid_r <= 1'b1;
        job_phase_r <= 1'b0;
      end else if (job_done) begin
        job_valid_r <= 1'b0;
      end else if (move) begin
        job_phase_r <= 1'b1;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      lcol_r <= line_started_r ? ccol_r : col_in;
      ccol_r <= col_in;
    end
    if (makes_job) begin
      job_lc_r   <= line_started_r ? lcol_r : col_in;
      job_cc_r   <= line_started_r ? ccol_r : col_in;
      job_rc_r   <= col_in;
      job_two_r  <= line_started_r && in_line_end;
      job_edge_r <= !line_started_r;
    end
    if (move) begin
      out_pix_r       <= blk;
      out_line_last_r <= job_phase_r || job_edge_r;
      out_run_last_r  <= job_phase_r || !job_two_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_r0c0            = sc3x_pkg::PORT_BITS'(out_pix_r[0]);
  assign out_r0c1            = sc3x_pkg::PORT_BITS'(out_pix_r[1]);
  assign out_r0c2            = sc3x_pkg::PORT_BITS'(out_pix_r[2]);
  assign out_r1c0            = sc3x_pkg::PORT_BITS'(out_pix_r[3]);
  assign out_r1c1            = sc3x_pkg::PORT_BITS'(out_pix_r[4]);
  assign out_r1c2            = sc3x_pkg::PORT_BITS'(out_pix_r[5]);
  assign out_r2c0            = sc3x_pkg::PORT_BITS'(out_pix_r[6]);
  assign out_r2c1            = sc3x_pkg::PORT_BITS'(out_pix_r[7]);
  assign out_r2c2            = sc3x_pkg::PORT_BITS'(out_pix_r[8]);
  assign out_block_line_last = out_line_last_r;
  assign out_run_last        = out_run_last_r;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !job_valid_r)
    else $error("pipeline not empty after reset");

  a_phase_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r && job_phase_r |-> job_two_r)
    else $error("second block phase on a single-block job");

  a_pair_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r && job_two_r && !job_phase_r |-> !in_ready)
    else $error("input taken while the first block of a pair is pending");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !out_run_last_r |=> out_valid_r && out_run_last_r)
    else $error("second block of a line end did not follow the first");

  a_line_last_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_line_last_r |-> out_run_last_r)
    else $error("line-end block not marked as final word of its column");
`endif

endmodule
